// ===== rtl/lcd_nibble_write_sequencer_assert.svh =====
// Assertion macros for the LCD nibble write sequencer.
// Expects aclk and aresetn in the scope of each use.
`ifndef LCD_NIBBLE_WRITE_SEQUENCER_ASSERT_SVH
`define LCD_NIBBLE_WRITE_SEQUENCER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define LCDNW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lcdnw: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define LCDNW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lcdnw: next-cycle check failed");

`endif

// ===== rtl/lcdnw_pkg.sv =====
// Shared types, constants and functions of the LCD nibble write sequencer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lcdnw_pkg;

    localparam int unsigned HOLD_W = 24;
    localparam logic [HOLD_W-1:0] HOLD_RESET = 24'd160000;
    localparam logic [0:0] REG_HOLD_CYCLES = 1'b0;
    localparam logic [2:0] LAST_STEP = 3'd6;
    localparam logic [1:0] STARTUP_LAST_INDEX = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       sel;
        logic       last;
    } lcdnw_op_t;

    typedef struct packed {
        logic       enable;
        logic       rs;
        logic [3:0] nibble;
    } lcdnw_pins_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SHOW,
        BK_HOLD
    } lcdnw_back_state_t;

    function automatic logic [7:0] startup_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0: b = 8'h33;
            2'd1: b = 8'h32;
            2'd2: b = 8'h01;
            2'd3: b = 8'h02;
            default: b = 8'h33;
        endcase
        return b;
    endfunction

    function automatic lcdnw_pins_t pin_state(input logic [7:0] b, input logic rs,
                                              input logic [2:0] step);
        lcdnw_pins_t p;
        p.rs = rs;
        case (step)
            3'd0: begin p.enable = 1'b1; p.nibble = 4'h0;   end
            3'd1: begin p.enable = 1'b1; p.nibble = b[7:4]; end
            3'd2: begin p.enable = 1'b0; p.nibble = b[7:4]; end
            3'd3: begin p.enable = 1'b1; p.nibble = b[7:4]; end
            3'd4: begin p.enable = 1'b1; p.nibble = b[3:0]; end
            3'd5: begin p.enable = 1'b0; p.nibble = b[3:0]; end
            3'd6: begin p.enable = 1'b1; p.nibble = b[3:0]; end
            default: begin p.enable = 1'b1; p.nibble = 4'h0; end
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/lcd_nibble_write_sequencer.sv =====
// Top level of the LCD nibble write sequencer: register port, front end, queue, back end.
// Depends on lcdnw_pkg, lcdnw_front, lcdnw_queue and lcdnw_back.
//
// Each request either writes one byte (tuser[0] low, byte in tdata, tuser[1] high for data)
// or runs the start-up sequence 0x33, 0x32, 0x01, 0x02 as commands (tuser[0] high). A byte
// gives seven pin states on the master side. Each state is offered until it is taken, then
// held by the hold counter in the back end, loaded from hold_cycles (zero acts as one). After
// the last state the back end returns to idle to load the next byte. Requests are taken
// while earlier bytes still run, up to the queue depth. tlast marks the final pin state
// of a request.
`timescale 1ns / 1ps
`default_nettype none
module lcd_nibble_write_sequencer #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] value
    input  wire  [1:0]  s_tuser,   // [0] func, [1] is_data
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,   // [0] pin_enable, [1] pin_select, [5:2] pin_nibble, [7:6] zero
    output logic        m_tlast    // last
);
    import lcdnw_pkg::*;

    logic [HOLD_W-1:0] hold_cycles_reg;
    logic              reg_hit;
    logic              f_valid, f_ready;
    lcdnw_op_t         f_op;
    logic              q_valid, q_ready;
    lcdnw_op_t         q_op;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2:2] == REG_HOLD_CYCLES);
    assign prdata  = reg_hit ? {{(32 - HOLD_W){1'b0}}, hold_cycles_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_cycles_reg <= HOLD_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            hold_cycles_reg <= pwdata[HOLD_W-1:0];
        end
    end

    lcdnw_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .op_valid (f_valid),
        .op_ready (f_ready),
        .op       (f_op)
    );

    lcdnw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_op     (f_op),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_op    (q_op)
    );

    lcdnw_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .hold_cycles (hold_cycles_reg),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_op        (q_op),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule
`default_nettype wire

// ===== rtl/lcdnw_front.sv =====
// Front end: accepts requests and expands them into byte operations.
// Depends on lcdnw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lcdnw_front (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_tvalid,
    output logic                   s_tready,
    input  wire  [7:0]             s_tdata,
    input  wire  [1:0]             s_tuser,
    output logic                   op_valid,
    input  wire                    op_ready,
    output lcdnw_pkg::lcdnw_op_t   op
);
    import lcdnw_pkg::*;

    logic       op_valid_reg, op_valid_next;
    logic       startup_reg, startup_next;
    logic [1:0] index_reg, index_next;
    logic [7:0] value_reg, value_next;
    logic       is_data_reg, is_data_next;
    logic       op_final;
    logic       accept;

    assign op_final = !startup_reg || (index_reg == STARTUP_LAST_INDEX);
    assign s_tready = !op_valid_reg || (op_ready && op_final);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        op_valid_next = op_valid_reg;
        startup_next  = startup_reg;
        index_next    = index_reg;
        value_next    = value_reg;
        is_data_next  = is_data_reg;
        if (accept) begin
            op_valid_next = 1'b1;
            startup_next  = s_tuser[0];
            index_next    = 2'd0;
            value_next    = s_tdata;
            is_data_next  = s_tuser[1];
        end else if (op_valid_reg && op_ready) begin
            if (op_final) begin
                op_valid_next = 1'b0;
            end else begin
                index_next = index_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_valid_reg <= 1'b0;
            startup_reg  <= 1'b0;
            index_reg    <= 2'd0;
        end else begin
            op_valid_reg <= op_valid_next;
            startup_reg  <= startup_next;
            index_reg    <= index_next;
        end
        value_reg   <= value_next;
        is_data_reg <= is_data_next;
    end

    assign op_valid     = op_valid_reg;
    assign op.data_byte = startup_reg ? startup_byte(index_reg) : value_reg;
    assign op.sel       = startup_reg ? 1'b0 : is_data_reg;
    assign op.last      = op_final;

endmodule
`default_nettype wire

// ===== rtl/lcdnw_queue.sv =====
// Short queue of byte operations between front end and sequencer.
// Depends on lcdnw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lcdnw_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  lcdnw_pkg::lcdnw_op_t   in_op,
    output logic                   out_valid,
    input  wire                    out_ready,
    output lcdnw_pkg::lcdnw_op_t   out_op
);
    import lcdnw_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    lcdnw_op_t        slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_FULL);
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_op    = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_op;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/lcdnw_back.sv =====
// Back end: steps one byte through its seven pin states with the hold timer.
// Depends on lcdnw_pkg and lcd_nibble_write_sequencer_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "lcd_nibble_write_sequencer_assert.svh"
module lcdnw_back (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire  [lcdnw_pkg::HOLD_W-1:0] hold_cycles,
    input  wire                         q_valid,
    output logic                        q_ready,
    input  lcdnw_pkg::lcdnw_op_t        q_op,
    output logic                        m_tvalid,
    input  wire                         m_tready,
    output logic [7:0]                  m_tdata,
    output logic                        m_tlast
);
    import lcdnw_pkg::*;

    lcdnw_back_state_t state_reg, state_next;
    logic [2:0]        step_reg, step_next;
    lcdnw_op_t         op_reg, op_next;
    logic [HOLD_W-1:0] hold_count_reg, hold_count_next;
    lcdnw_pins_t       pins;

    always_comb begin
        state_next      = state_reg;
        step_next       = step_reg;
        op_next         = op_reg;
        hold_count_next = hold_count_reg;
        case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    op_next    = q_op;
                    step_next  = 3'd0;
                    state_next = BK_SHOW;
                end
            end
            BK_SHOW: begin
                if (m_tready) begin
                    hold_count_next = (hold_cycles == '0) ? HOLD_W'(1) : hold_cycles;
                    state_next      = BK_HOLD;
                end
            end
            BK_HOLD: begin
                if (hold_count_reg <= HOLD_W'(1)) begin
                    if (step_reg == LAST_STEP) begin
                        state_next = BK_IDLE;
                    end else begin
                        step_next  = step_reg + 3'd1;
                        state_next = BK_SHOW;
                    end
                end else begin
                    hold_count_next = hold_count_reg - HOLD_W'(1);
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        pins     = pin_state(op_reg.data_byte, op_reg.sel, step_reg);
        q_ready  = (state_reg == BK_IDLE);
        m_tvalid = (state_reg == BK_SHOW);
        m_tdata  = {2'b00, pins.nibble, pins.rs, pins.enable};
        m_tlast  = op_reg.last && (step_reg == LAST_STEP);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BK_IDLE;
            step_reg       <= 3'd0;
            hold_count_reg <= '0;
        end else begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            hold_count_reg <= hold_count_next;
        end
        op_reg <= op_next;
    end

    `LCDNW_ASSERT_NOW(a_step_range, 1'b1, step_reg <= LAST_STEP)
    `LCDNW_ASSERT_NOW(a_pop_idle, q_valid && q_ready, !m_tvalid)
    `LCDNW_ASSERT_NEXT(a_show_to_hold, m_tvalid && m_tready,
                       state_reg == BK_HOLD && hold_count_reg != '0)
    `LCDNW_ASSERT_NEXT(a_end_of_byte,
                       state_reg == BK_HOLD && hold_count_reg <= HOLD_W'(1) && step_reg == LAST_STEP,
                       state_reg == BK_IDLE)

endmodule
`default_nettype wire

// ===== bench/lcd_nibble_write_sequencer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the LCD nibble write sequencer: byte writes and start-up
// requests in, expected pin states predicted per request and checked in order.
// Depends on lcdnw_pkg and lcd_nibble_write_sequencer.
module lcd_nibble_write_sequencer_tb;
    import lcdnw_pkg::*;

    localparam logic FUNC_WRITE   = 1'b0;
    localparam logic FUNC_STARTUP = 1'b1;
    localparam logic [2:0] HOLD_ADDR     = {REG_HOLD_CYCLES, 2'b00};
    localparam logic [2:0] UNMAPPED_ADDR = 3'd4;
    localparam logic [31:0] STARTUP_SEQ  = 32'h02013233;
    localparam logic [6:0] ENABLE_STEPS  = 7'b1011011;
    localparam int STEPS_PER_BYTE = 7;
    localparam int IDLE_PERCENT   = 35;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT  = 5000;

    typedef struct packed {
        logic       enable;
        logic       rs;
        logic [3:0] nibble;
        logic       last;
    } pin_expect_t;

    class pin_scoreboard;
        pin_expect_t pin_queue[$];
        logic [HOLD_W-1:0] hold_setting;
        logic [7:0] sent_byte;
        logic sent_select;
        int failures;

        function new();
            hold_setting = HOLD_RESET;
            sent_byte = 8'h00;
            sent_select = 1'b0;
            failures = 0;
        endfunction

        function void queue_byte(input logic [7:0] b, input logic rs, input logic final_byte);
            pin_expect_t p;
            sent_byte = b;
            sent_select = rs;
            for (int step = 0; step < STEPS_PER_BYTE; step++) begin
                p.enable = ENABLE_STEPS[step];
                p.rs = rs;
                p.nibble = (step == 0) ? 4'h0 : (step < 4 ? b[7:4] : b[3:0]);
                p.last = final_byte && (step == STEPS_PER_BYTE - 1);
                pin_queue.push_back(p);
            end
        endfunction

        function void note_request(input logic func, input logic [7:0] value,
                                   input logic is_data);
            if (func == FUNC_WRITE) begin
                queue_byte(value, is_data, 1'b1);
            end else begin
                for (int i = 0; i < 4; i++)
                    queue_byte(STARTUP_SEQ[8*i +: 8], 1'b0, i == 3);
            end
        endfunction

        function void compare_field(input string field, input logic [3:0] want,
                                    input logic [3:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
                failures++;
            end
        endfunction

        function void check_pins(input logic [7:0] tdata, input logic tlast);
            pin_expect_t e;
            if (pin_queue.size() == 0) begin
                $display("%0t: unexpected pin state, expected none, got tdata=%h tlast=%b",
                         $time, tdata, tlast);
                failures++;
                return;
            end
            e = pin_queue.pop_front();
            compare_field("pin_enable", {3'b0, e.enable}, {3'b0, tdata[0]});
            compare_field("pin_select", {3'b0, e.rs}, {3'b0, tdata[1]});
            compare_field("pin_nibble", e.nibble, tdata[5:2]);
            compare_field("last", {3'b0, e.last}, {3'b0, tlast});
        endfunction

        function int pending_count();
            return pin_queue.size();
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic pready;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = 8'h00;    // [7:0] value
    logic [1:0] s_tuser = 2'b00;    // [0] func, [1] is_data
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [7:0] m_tdata;            // [0] pin_enable, [1] pin_select, [5:2] pin_nibble
    logic m_tlast;

    pin_scoreboard sb = new();
    bit sender_calm = 1'b0;
    bit sink_calm = 1'b0;
    bit hold_off_request = 1'b0;
    int stall_left = 0;
    int quiet_cycles = 0;

    lcd_nibble_write_sequencer dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready)
                sb.check_pins(m_tdata, m_tlast);
            if (hold_off_request) begin
                stall_left = HOLD_OFF_CYCLES;
                hold_off_request = 1'b0;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= sink_calm || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_hold_readback();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= HOLD_ADDR;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata[HOLD_W-1:0] !== sb.hold_setting) begin
            $display("%0t: hold_cycles readback mismatch, expected %h, got %h",
                     $time, sb.hold_setting, prdata[HOLD_W-1:0]);
            sb.failures++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic program_hold(input logic [HOLD_W-1:0] cycles);
        apb_write(HOLD_ADDR, {8'h00, cycles});
        sb.hold_setting = cycles;
        check_hold_readback();
    endtask

    task automatic send_request(input logic func, input logic [7:0] value,
                                input logic is_data);
        while (!sender_calm && $urandom_range(99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= value;
        s_tuser <= {is_data, func};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        sb.note_request(func, value, is_data);
    endtask

    task automatic settle();
        int hold;
        while (sb.pending_count() != 0)
            @(posedge aclk);
        hold = (sb.hold_setting == 0) ? 1 : int'(sb.hold_setting);
        repeat (2 * (hold + 1) + 8) @(posedge aclk);
    endtask

    task automatic run_random(input int count);
        logic func;
        for (int n = 0; n < count; n++) begin
            func = ($urandom_range(99) < 20) ? FUNC_STARTUP : FUNC_WRITE;
            send_request(func, 8'($urandom_range(255)), 1'($urandom_range(1)));
        end
        s_tvalid <= 1'b0;
        settle();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        check_hold_readback();
        program_hold(24'd1);

        send_request(FUNC_WRITE, 8'h00, 1'b0);
        send_request(FUNC_WRITE, 8'hFF, 1'b1);
        send_request(FUNC_WRITE, 8'hA5, 1'b0);
        send_request(FUNC_WRITE, 8'h5A, 1'b1);
        send_request(FUNC_WRITE, 8'h0F, 1'b0);
        send_request(FUNC_WRITE, 8'hF0, 1'b1);
        // start-up ignores value and is_data
        send_request(FUNC_STARTUP, 8'hFF, 1'b1);
        send_request(FUNC_STARTUP, 8'h00, 1'b0);
        send_request(FUNC_WRITE, 8'h33, 1'b1);
        send_request(FUNC_WRITE, 8'h80, 1'b0);
        send_request(FUNC_WRITE, 8'h01, 1'b1);
        s_tvalid <= 1'b0;
        settle();

        // zero hold behaves as a hold setting of one
        program_hold(24'd0);
        send_request(FUNC_WRITE, 8'hC3, 1'b1);
        send_request(FUNC_STARTUP, 8'h7E, 1'b0);
        s_tvalid <= 1'b0;
        settle();

        program_hold(24'hFFFFFF);
        // write beyond the register list: hold_cycles must not change
        apb_write(UNMAPPED_ADDR, 32'h0000_0005);
        check_hold_readback();
        program_hold(24'd2);

        sender_calm = 1'b1;
        sink_calm = 1'b1;
        run_random(25);

        sink_calm = 1'b0;
        program_hold(24'd1);
        hold_off_request = 1'b1;
        run_random(25);

        sender_calm = 1'b0;
        program_hold(24'd5);
        run_random(25);

        program_hold(24'd0);
        run_random(25);

        if (sb.failures == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
